@@ design/bcc_pkg.sv @@
// Shared types and constants for the barometer conversion and compensation block.
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgAddrW = 3;
  localparam logic [CfgAddrW-1:0] REG_SENS_COEF        = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_OFFSET_COEF      = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_SENS_TEMP_COEF   = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_OFFSET_TEMP_COEF = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_REF_TEMP_COEF    = 3'd4;
  localparam logic [CfgAddrW-1:0] REG_TEMP_SENS_COEF   = 3'd5;
  localparam logic [CfgAddrW-1:0] REG_DEVICE_PRESENT   = 3'd6;

  // Field widths.
  localparam int unsigned CoefW  = 16;
  localparam int unsigned AdcW   = 24;
  localparam int unsigned TempW  = 19;
  localparam int unsigned PressW = 32;

  // Shared multiplier operand and product widths.
  localparam int unsigned MulW  = 26;
  localparam int unsigned ProdW = 2 * MulW;

  // Compensation constants.
  localparam logic signed [TempW-1:0] TEMP_REF  = 19'sd2000;
  localparam logic signed [TempW-1:0] TEMP_COLD = -19'sd1500;

  // Operand selection for the shared multiplier.
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_DT_C6,
    MUL_C4_DT,
    MUL_C3_DT,
    MUL_DT_DT,
    MUL_D_D,
    MUL_E_E,
    MUL_D1_LO,
    MUL_D1_HI
  } mul_op_e;

  // Which datapath update is applied; most of them take the product that the multiplier holds.
  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_TEMP,
    STEP_OFF,
    STEP_SENS,
    STEP_T2,
    STEP_DD,
    STEP_EE,
    STEP_ADJ,
    STEP_LO,
    STEP_HI,
    STEP_SUB,
    STEP_SAT
  } step_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_TC,
    ST_MUL_OFF,
    ST_MUL_SENS,
    ST_MUL_T2,
    ST_MUL_D,
    ST_MUL_E,
    ST_SQ_E,
    ST_ADJ,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACC,
    ST_SUB,
    ST_SAT,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;
    mul_op_e op;
    step_e   step;
    logic    load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_comp;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ design/bcc_mul.sv @@
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none

module bcc_mul (
  input  wire                                    clk_i,
  input  wire  logic signed [bcc_pkg::MulW-1:0]  a_i,
  input  wire  logic signed [bcc_pkg::MulW-1:0]  b_i,
  output logic signed [bcc_pkg::ProdW-1:0]       p_o
);

  logic signed [bcc_pkg::ProdW-1:0] p_q;

  // One product per cycle, registered before any use.
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

@@ design/bcc_datapath.sv @@
// Datapath: calibration registers, conversion state, compensation arithmetic and output word.
`timescale 1ns / 1ps
`default_nettype none

module bcc_datapath (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire                                       cfg_we_i,
  input  wire  logic [bcc_pkg::CfgAddrW-1:0]        cfg_addr_i,
  input  wire  logic [bcc_pkg::CoefW-1:0]           cfg_wdata_i,
  input  wire                                       read_ok_i,
  input  wire  logic [bcc_pkg::AdcW-1:0]            adc_value_i,
  input  wire  bcc_pkg::cmd_t                       cmd_i,
  output bcc_pkg::sts_t                             sts_o,
  input  wire                                       out_stall_i,
  output logic                                      out_valid_o,
  output logic                                      result_valid_o,
  output logic signed [bcc_pkg::TempW-1:0]          temperature_centi_o,
  output logic signed [bcc_pkg::PressW-1:0]         pressure_pa_o,
  output logic                                      start_temperature_o
);

  localparam int unsigned DtW   = bcc_pkg::AdcW + 1;
  localparam int unsigned WideW = 42;
  localparam int unsigned AccW  = 66;
  localparam int unsigned DiffW = 46;
  localparam int unsigned T2W   = 18;
  localparam int unsigned DeW   = bcc_pkg::TempW + 1;

  // Calibration words and presence flag.
  logic [bcc_pkg::CoefW-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
  logic                      dev_q;

  // Conversion sequencing state.
  logic                      wait_q, wait_d;
  logic [bcc_pkg::AdcW-1:0]  raw_q;

  // Working registers of the compensation.
  logic signed [DtW-1:0]                dt_q;
  logic signed [bcc_pkg::TempW-1:0]     temp_q;
  logic signed [WideW-1:0]              off_q, sens_q, off2_q, sens2_q;
  logic        [T2W-1:0]                t2_q;
  logic signed [AccW-1:0]               acc_q;
  logic signed [DiffW-1:0]              diff_q;

  // Result word and output register.
  logic                                 res_valid_q, res_start_q;
  logic signed [bcc_pkg::TempW-1:0]     res_temp_q;
  logic signed [bcc_pkg::PressW-1:0]    res_press_q;
  logic                                 out_valid_q;
  logic                                 out_res_valid_q, out_start_q;
  logic signed [bcc_pkg::TempW-1:0]     out_temp_q;
  logic signed [bcc_pkg::PressW-1:0]    out_press_q;

  logic                                 good;
  logic signed [DtW-1:0]                dt_d;
  logic signed [DeW-1:0]                d_w, e_w;
  logic signed [bcc_pkg::MulW-1:0]      mul_a, mul_b;
  logic signed [bcc_pkg::ProdW-1:0]     prod;
  logic signed [bcc_pkg::ProdW-1:0]     p_sh23, p_sh7, p_sh8;
  logic signed [WideW-1:0]              p_w, five_p, seven_p, eleven_p;
  logic signed [AccW-1:0]               acc_sh;
  logic signed [DiffW-1:0]              p_sh15;
  logic                                 lt_ref, lt_cold;

  // Item decode and next value of the waiting flag.
  assign good = read_ok_i && (adc_value_i != '0);
  assign sts_o.need_comp = dev_q && wait_q && good;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    if (!dev_q) begin
      wait_d = wait_q;
    end else if (!wait_q) begin
      wait_d = good;
    end else begin
      wait_d = 1'b0;
    end
  end

  // Temperature difference from the reference word, formed at accept.
  assign dt_d = $signed({1'b0, adc_value_i}) - $signed({1'b0, c5_q, 8'h00});

  // Differences of the first-order temperature from the two thresholds.
  assign d_w = DeW'(temp_q) - DeW'(bcc_pkg::TEMP_REF);
  assign e_w = DeW'(temp_q) - DeW'(bcc_pkg::TEMP_COLD);
  assign lt_ref  = temp_q < bcc_pkg::TEMP_REF;
  assign lt_cold = temp_q < bcc_pkg::TEMP_COLD;

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd_i.op)
      bcc_pkg::MUL_DT_C6: begin
        mul_a = bcc_pkg::MulW'(dt_q);
        mul_b = $signed({10'b0, c6_q});
      end
      bcc_pkg::MUL_C4_DT: begin
        mul_a = $signed({10'b0, c4_q});
        mul_b = bcc_pkg::MulW'(dt_q);
      end
      bcc_pkg::MUL_C3_DT: begin
        mul_a = $signed({10'b0, c3_q});
        mul_b = bcc_pkg::MulW'(dt_q);
      end
      bcc_pkg::MUL_DT_DT: begin
        mul_a = bcc_pkg::MulW'(dt_q);
        mul_b = bcc_pkg::MulW'(dt_q);
      end
      bcc_pkg::MUL_D_D: begin
        mul_a = bcc_pkg::MulW'(d_w);
        mul_b = bcc_pkg::MulW'(d_w);
      end
      bcc_pkg::MUL_E_E: begin
        mul_a = bcc_pkg::MulW'(e_w);
        mul_b = bcc_pkg::MulW'(e_w);
      end
      bcc_pkg::MUL_D1_LO: begin
        mul_a = $signed({2'b0, raw_q});
        mul_b = $signed({2'b0, sens_q[23:0]});
      end
      bcc_pkg::MUL_D1_HI: begin
        // The upper part carries the sign of the sensitivity.
        mul_a = $signed({2'b0, raw_q});
        mul_b = bcc_pkg::MulW'($signed(sens_q[WideW-1:24]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  bcc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Shifted and scaled forms of the product; the shifts are floor divisions.
  assign p_sh23   = prod >>> 23;
  assign p_sh7    = prod >>> 7;
  assign p_sh8    = prod >>> 8;
  assign p_w      = prod[WideW-1:0];
  assign five_p   = (p_w <<< 2) + p_w;
  assign seven_p  = (p_w <<< 3) - p_w;
  assign eleven_p = (p_w <<< 3) + (p_w <<< 1) + p_w;
  assign acc_sh   = acc_q >>> 21;
  assign p_sh15   = diff_q >>> 15;

  // Configuration and conversion state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q   <= '0;
      c2_q   <= '0;
      c3_q   <= '0;
      c4_q   <= '0;
      c5_q   <= '0;
      c6_q   <= '0;
      dev_q  <= 1'b0;
      wait_q <= 1'b0;
      raw_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          bcc_pkg::REG_SENS_COEF:        c1_q  <= cfg_wdata_i;
          bcc_pkg::REG_OFFSET_COEF:      c2_q  <= cfg_wdata_i;
          bcc_pkg::REG_SENS_TEMP_COEF:   c3_q  <= cfg_wdata_i;
          bcc_pkg::REG_OFFSET_TEMP_COEF: c4_q  <= cfg_wdata_i;
          bcc_pkg::REG_REF_TEMP_COEF:    c5_q  <= cfg_wdata_i;
          bcc_pkg::REG_TEMP_SENS_COEF:   c6_q  <= cfg_wdata_i;
          bcc_pkg::REG_DEVICE_PRESENT:   dev_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        wait_q <= wait_d;
        if (dev_q && !wait_q && good) begin
          raw_q <= adc_value_i;
        end
      end
    end
  end

  // Compensation steps, one step per cycle as the controller directs; a step may update several registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      dt_q        <= dt_d;
      res_valid_q <= 1'b0;
      res_temp_q  <= '0;
      res_press_q <= '0;
      res_start_q <= wait_d;
    end
    case (cmd_i.step)
      bcc_pkg::STEP_TEMP: temp_q <= bcc_pkg::TEMP_REF + p_sh23[bcc_pkg::TempW-1:0];
      bcc_pkg::STEP_OFF:  off_q  <= $signed({10'b0, c2_q, 16'b0}) + p_sh7[WideW-1:0];
      bcc_pkg::STEP_SENS: sens_q <= $signed({11'b0, c1_q, 15'b0}) + p_sh8[WideW-1:0];
      bcc_pkg::STEP_T2:   t2_q   <= prod[48:31];
      bcc_pkg::STEP_DD: begin
        off2_q  <= five_p >>> 1;
        sens2_q <= five_p >>> 2;
      end
      bcc_pkg::STEP_EE: begin
        // Extra term below the cold threshold.
        if (lt_cold) begin
          off2_q  <= off2_q + seven_p;
          sens2_q <= sens2_q + (eleven_p >>> 1);
        end
      end
      bcc_pkg::STEP_ADJ: begin
        // Second-order correction, gated on the first-order temperature.
        if (lt_ref) begin
          temp_q <= temp_q - $signed({1'b0, t2_q});
          off_q  <= off_q - off2_q;
          sens_q <= sens_q - sens2_q;
        end
      end
      bcc_pkg::STEP_LO:  acc_q  <= AccW'(prod);
      bcc_pkg::STEP_HI:  acc_q  <= acc_q + (AccW'(prod) <<< 24);
      bcc_pkg::STEP_SUB: diff_q <= acc_sh[DiffW-1:0] - DiffW'(off_q);
      bcc_pkg::STEP_SAT: begin
        // The scaled pressure spans at most 27 signed bits, so it always
        // lies inside the 32-bit range and its low bits are the result.
        res_valid_q <= 1'b1;
        res_temp_q  <= temp_q;
        res_press_q <= p_sh15[bcc_pkg::PressW-1:0];
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_res_valid_q <= res_valid_q;
      out_temp_q      <= res_temp_q;
      out_press_q     <= res_press_q;
      out_start_q     <= res_start_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign result_valid_o      = out_res_valid_q;
  assign temperature_centi_o = out_temp_q;
  assign pressure_pa_o       = out_press_q;
  assign start_temperature_o = out_start_q;

  // A compensated pair always comes with a pressure restart.
  a_valid_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_valid_q |-> !out_start_q)
    else $error("compensated result does not restart pressure conversion");

  // An absent device leaves the sequencing state untouched.
  a_absent_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept && !dev_q |=> $stable(wait_q))
    else $error("waiting flag changed while device absent");

  // A compensating read returns the sequencer to the pressure phase.
  a_comp_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept && sts_o.need_comp |=> !wait_q)
    else $error("waiting flag still set after temperature read");

endmodule

`default_nettype wire

@@ design/bcc_ctrl.sv @@
// Controller: input handshake and the compensation step sequencer.
`timescale 1ns / 1ps
`default_nettype none

module bcc_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire  bcc_pkg::sts_t sts_i,
  output bcc_pkg::cmd_t       cmd_o
);

  bcc_pkg::state_e state_q, state_d;
  logic            accept;

  assign accept = (state_q == bcc_pkg::ST_IDLE) && in_valid_i;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    case (state_q)
      bcc_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = sts_i.need_comp ? bcc_pkg::ST_MUL_TC : bcc_pkg::ST_DONE;
        end else begin
          state_d = bcc_pkg::ST_IDLE;
        end
      end
      bcc_pkg::ST_MUL_TC:   state_d = bcc_pkg::ST_MUL_OFF;
      bcc_pkg::ST_MUL_OFF:  state_d = bcc_pkg::ST_MUL_SENS;
      bcc_pkg::ST_MUL_SENS: state_d = bcc_pkg::ST_MUL_T2;
      bcc_pkg::ST_MUL_T2:   state_d = bcc_pkg::ST_MUL_D;
      bcc_pkg::ST_MUL_D:    state_d = bcc_pkg::ST_MUL_E;
      bcc_pkg::ST_MUL_E:    state_d = bcc_pkg::ST_SQ_E;
      bcc_pkg::ST_SQ_E:     state_d = bcc_pkg::ST_ADJ;
      bcc_pkg::ST_ADJ:      state_d = bcc_pkg::ST_MUL_LO;
      bcc_pkg::ST_MUL_LO:   state_d = bcc_pkg::ST_MUL_HI;
      bcc_pkg::ST_MUL_HI:   state_d = bcc_pkg::ST_ACC;
      bcc_pkg::ST_ACC:      state_d = bcc_pkg::ST_SUB;
      bcc_pkg::ST_SUB:      state_d = bcc_pkg::ST_SAT;
      bcc_pkg::ST_SAT:      state_d = bcc_pkg::ST_DONE;
      bcc_pkg::ST_DONE: begin
        state_d = sts_i.out_free ? bcc_pkg::ST_IDLE : bcc_pkg::ST_DONE;
      end
      default: state_d = bcc_pkg::ST_IDLE;
    endcase
  end

  // Outputs: a state may issue a product and may retire an earlier one.
  always_comb begin
    in_stall_o     = (state_q != bcc_pkg::ST_IDLE);
    cmd_o.accept   = accept;
    cmd_o.op       = bcc_pkg::MUL_NONE;
    cmd_o.step     = bcc_pkg::STEP_NONE;
    cmd_o.load_out = 1'b0;
    case (state_q)
      bcc_pkg::ST_MUL_TC: begin
        cmd_o.op = bcc_pkg::MUL_DT_C6;
      end
      bcc_pkg::ST_MUL_OFF: begin
        cmd_o.op   = bcc_pkg::MUL_C4_DT;
        cmd_o.step = bcc_pkg::STEP_TEMP;
      end
      bcc_pkg::ST_MUL_SENS: begin
        cmd_o.op   = bcc_pkg::MUL_C3_DT;
        cmd_o.step = bcc_pkg::STEP_OFF;
      end
      bcc_pkg::ST_MUL_T2: begin
        cmd_o.op   = bcc_pkg::MUL_DT_DT;
        cmd_o.step = bcc_pkg::STEP_SENS;
      end
      bcc_pkg::ST_MUL_D: begin
        cmd_o.op   = bcc_pkg::MUL_D_D;
        cmd_o.step = bcc_pkg::STEP_T2;
      end
      bcc_pkg::ST_MUL_E: begin
        cmd_o.op   = bcc_pkg::MUL_E_E;
        cmd_o.step = bcc_pkg::STEP_DD;
      end
      bcc_pkg::ST_SQ_E:   cmd_o.step = bcc_pkg::STEP_EE;
      bcc_pkg::ST_ADJ:    cmd_o.step = bcc_pkg::STEP_ADJ;
      bcc_pkg::ST_MUL_LO: cmd_o.op   = bcc_pkg::MUL_D1_LO;
      bcc_pkg::ST_MUL_HI: begin
        cmd_o.op   = bcc_pkg::MUL_D1_HI;
        cmd_o.step = bcc_pkg::STEP_LO;
      end
      bcc_pkg::ST_ACC:  cmd_o.step     = bcc_pkg::STEP_HI;
      bcc_pkg::ST_SUB:  cmd_o.step     = bcc_pkg::STEP_SUB;
      bcc_pkg::ST_SAT:  cmd_o.step     = bcc_pkg::STEP_SAT;
      bcc_pkg::ST_DONE: cmd_o.load_out = sts_i.out_free;
      default: ;
    endcase
  end

  // A compensating read starts the multiply sequence right away.
  a_comp_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && sts_i.need_comp |=> state_q == bcc_pkg::ST_MUL_TC)
    else $error("compensation sequence did not start");

  // Any other read goes straight to delivery.
  a_plain_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !sts_i.need_comp |=> state_q == bcc_pkg::ST_DONE)
    else $error("plain read did not go to delivery");

  // The output register is loaded only when it has room.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> sts_i.out_free)
    else $error("output register overwritten");

endmodule

`default_nettype wire

@@ design/barometer_conversion_compensation.sv @@
// Top level of the barometer conversion sequencer with temperature compensation.
`timescale 1ns / 1ps
`default_nettype none

// Each input word is one ADC read with a bus-ok flag, and each yields one
// output word that also names the next conversion to command. A read that
// needs no compensation goes from acceptance straight to the delivery state
// and then to the output register; a good temperature read first runs the
// single shared 26 x 26 bit multiplier, which forms eight products in turn,
// followed by the accumulate, subtract and scaling steps. The block takes a
// new word only while its sequencer is idle, so it takes no word before the
// last one has been loaded into the output register, and it accepts
// one while the previous result still waits in the output register. The user
// writes calibration words through the plain write port while the block is idle;
// the block does not enforce this, and there is no clearing pass after reset.
module barometer_conversion_compensation (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     cfg_we_i,
  input  wire  logic [bcc_pkg::CfgAddrW-1:0]      cfg_addr_i,
  input  wire  logic [bcc_pkg::CoefW-1:0]         cfg_wdata_i,
  input  wire                                     in_valid_i,
  output logic                                    in_stall_o,
  input  wire                                     read_ok_i,
  input  wire  logic [bcc_pkg::AdcW-1:0]          adc_value_i,
  output logic                                    out_valid_o,
  input  wire                                     out_stall_i,
  output logic                                    result_valid_o,
  output logic signed [bcc_pkg::TempW-1:0]        temperature_centi_o,
  output logic signed [bcc_pkg::PressW-1:0]       pressure_pa_o,
  output logic                                    start_temperature_o
);

  bcc_pkg::cmd_t cmd;
  bcc_pkg::sts_t sts;

  // Step sequencer.
  bcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Arithmetic, state and output register.
  bcc_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_addr_i          (cfg_addr_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .read_ok_i           (read_ok_i),
    .adc_value_i         (adc_value_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .out_stall_i         (out_stall_i),
    .out_valid_o         (out_valid_o),
    .result_valid_o      (result_valid_o),
    .temperature_centi_o (temperature_centi_o),
    .pressure_pa_o       (pressure_pa_o),
    .start_temperature_o (start_temperature_o)
  );

endmodule

`default_nettype wire
